/* hdl/usp_pkg.sv */
// Shared types, codes and tables for the URL scheme/host/port tagger.
// Used by usp_step, the top level and the checker; depends on nothing.
`default_nettype none

package usp_pkg;

	localparam int SCHEME_COUNT = 9;
	localparam int SCHEME_COLS  = 8;
	localparam int TDATA_W      = 48;
	localparam int TUSER_W      = 3;

	localparam logic [3:0]  SCHEME_UNKNOWN = 4'd9;
	localparam logic [31:0] PORT_CAP       = 32'h8000_0000;
	localparam logic [31:0] PORT_MAX       = 32'h7FFF_FFFF;

	localparam logic [2:0] SEC_SCHEME = 3'd0;
	localparam logic [2:0] SEC_SEP    = 3'd1;
	localparam logic [2:0] SEC_HOST   = 3'd2;
	localparam logic [2:0] SEC_PORT   = 3'd3;
	localparam logic [2:0] SEC_PATH   = 3'd4;
	localparam logic [2:0] SEC_ERROR  = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_COLON  = 3'd1;
	localparam logic [2:0] ST_UNKNOWN   = 3'd2;
	localparam logic [2:0] ST_NO_SLASH  = 3'd3;
	localparam logic [2:0] ST_BAD_HOST  = 3'd4;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0] SCHEME_TAB [SCHEME_COUNT][SCHEME_COLS] = '{
		'{"h", "t", "t", "p", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"h", "t", "t", "p", "s",   8'h00, 8'h00, 8'h00},
		'{"f", "t", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"m", "a", "i", "l", "t",   "o",   8'h00, 8'h00},
		'{"l", "d", "a", "p", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "i", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"n", "e", "w", "s", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"g", "o", "p", "h", "e",   "r",   8'h00, 8'h00},
		'{"t", "e", "l", "n", "e",   "t",   8'h00, 8'h00}
	};

	localparam logic [2:0] SCHEME_LEN [SCHEME_COUNT] = '{
		3'd4, 3'd5, 3'd3, 3'd6, 3'd4, 3'd4, 3'd4, 3'd6, 3'd6
	};

	typedef enum logic [2:0] {
		PH_SCHEME = 3'd0,
		PH_SLASH1 = 3'd1,
		PH_SLASH2 = 3'd2,
		PH_HOST   = 3'd3,
		PH_PORT   = 3'd4,
		PH_PATH   = 3'd5,
		PH_ERROR  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		PS_SKIP   = 2'd0,
		PS_DIGITS = 2'd1,
		PS_DONE   = 2'd2
	} port_sub_t;

	typedef struct packed {
		phase_t              phase;
		logic [2:0]          scheme_len;
		logic [SCHEME_COUNT-1:0] cand;
		logic [3:0]          matched;
		logic                host_seen;
		port_sub_t           port_sub;
		logic                port_neg;
		logic [31:0]         port_acc;
		logic                port_text;
		logic [31:0]         committed_port;
		logic                port_committed;
		logic [2:0]          err;
	} parse_state_t;

	typedef struct packed {
		logic [7:0]  echo_byte;
		logic [2:0]  section;
		logic        final_res;
		logic [3:0]  scheme_code;
		logic [31:0] port_value;
		logic [2:0]  status;
	} result_t;

	function automatic parse_state_t start_state();
		parse_state_t s;
		s.phase          = PH_SCHEME;
		s.scheme_len     = '0;
		s.cand           = '1;
		s.matched        = SCHEME_UNKNOWN;
		s.host_seen      = 1'b0;
		s.port_sub       = PS_SKIP;
		s.port_neg       = 1'b0;
		s.port_acc       = '0;
		s.port_text      = 1'b0;
		s.committed_port = '0;
		s.port_committed = 1'b0;
		s.err            = ST_OK;
		return s;
	endfunction

endpackage

`default_nettype wire

/* hdl/usp_step.sv */
// Next-state and result logic for one character of the URL tagger.
// Purely combinational; uses the types, codes and scheme table of usp_pkg.
`default_nettype none

module usp_step (
	input  wire usp_pkg::parse_state_t cur,
	input  wire logic [7:0]            text_byte,
	input  wire logic                  last_byte,
	input  wire logic [15:0]           default_port,
	output usp_pkg::parse_state_t      nxt,
	output usp_pkg::result_t           res
);

	logic [7:0]  lb;
	logic        is_term;
	logic        is_space;
	logic        is_digit;
	logic [3:0]  found;
	logic [35:0] port_mul;
	logic [31:0] port_res;
	logic [2:0]  section;
	logic [2:0]  status;
	logic [31:0] report_port;
	usp_pkg::parse_state_t upd;

	assign lb = (text_byte >= "A" && text_byte <= "Z") ? text_byte + 8'd32 : text_byte;
	assign is_term = text_byte == usp_pkg::CH_SLASH || text_byte == usp_pkg::CH_QUEST ||
		text_byte == usp_pkg::CH_SEMI || text_byte == usp_pkg::CH_HASH;
	assign is_space = text_byte == usp_pkg::CH_SPACE ||
		(text_byte >= 8'd9 && text_byte <= 8'd13);
	assign is_digit = text_byte >= "0" && text_byte <= "9";

	assign port_mul = {cur.port_acc, 3'b000} + {2'b00, cur.port_acc, 1'b0} +
		{32'd0, text_byte[3:0] - 4'd0};
	assign port_res = cur.port_neg ? 32'd0 - cur.port_acc :
		(cur.port_acc >= usp_pkg::PORT_CAP ? usp_pkg::PORT_MAX : cur.port_acc);

	always_comb begin
		found = usp_pkg::SCHEME_UNKNOWN;
		for (int k = 0; k < usp_pkg::SCHEME_COUNT; k++) begin
			if (cur.cand[k] && usp_pkg::SCHEME_LEN[k] == cur.scheme_len) begin
				found = 4'(k);
			end
		end
	end

	always_comb begin
		upd     = cur;
		section = usp_pkg::SEC_ERROR;
		unique case (cur.phase)
			usp_pkg::PH_SCHEME: begin
				if (text_byte == usp_pkg::CH_COLON) begin
					if (cur.scheme_len == 3'd0) begin
						upd.err     = usp_pkg::ST_NO_COLON;
						upd.matched = usp_pkg::SCHEME_UNKNOWN;
						upd.phase   = usp_pkg::PH_ERROR;
					end else if (found == usp_pkg::SCHEME_UNKNOWN) begin
						upd.err     = usp_pkg::ST_UNKNOWN;
						upd.matched = usp_pkg::SCHEME_UNKNOWN;
						upd.phase   = usp_pkg::PH_ERROR;
					end else begin
						upd.matched = found;
						upd.phase   = usp_pkg::PH_SLASH1;
						section     = usp_pkg::SEC_SEP;
					end
				end else begin
					for (int k = 0; k < usp_pkg::SCHEME_COUNT; k++) begin
						if (cur.scheme_len >= usp_pkg::SCHEME_LEN[k] ||
							lb != usp_pkg::SCHEME_TAB[k][cur.scheme_len]) begin
							upd.cand[k] = 1'b0;
						end
					end
					if (cur.scheme_len != 3'd7) begin
						upd.scheme_len = cur.scheme_len + 3'd1;
					end
					section = usp_pkg::SEC_SCHEME;
				end
			end
			usp_pkg::PH_SLASH1, usp_pkg::PH_SLASH2: begin
				if (text_byte == usp_pkg::CH_SLASH) begin
					upd.phase = (cur.phase == usp_pkg::PH_SLASH1) ?
						usp_pkg::PH_SLASH2 : usp_pkg::PH_HOST;
					section = usp_pkg::SEC_SEP;
				end else begin
					upd.err     = usp_pkg::ST_NO_SLASH;
					upd.matched = usp_pkg::SCHEME_UNKNOWN;
					upd.phase   = usp_pkg::PH_ERROR;
				end
			end
			usp_pkg::PH_HOST: begin
				if (text_byte == usp_pkg::CH_COLON || is_term) begin
					if (!cur.host_seen) begin
						upd.err     = usp_pkg::ST_BAD_HOST;
						upd.matched = usp_pkg::SCHEME_UNKNOWN;
						upd.phase   = usp_pkg::PH_ERROR;
					end else if (text_byte == usp_pkg::CH_COLON) begin
						upd.phase = usp_pkg::PH_PORT;
						section   = usp_pkg::SEC_SEP;
					end else begin
						upd.phase = usp_pkg::PH_PATH;
						section   = usp_pkg::SEC_PATH;
					end
				end else begin
					upd.host_seen = 1'b1;
					section       = usp_pkg::SEC_HOST;
				end
			end
			usp_pkg::PH_PORT: begin
				if (is_term) begin
					if (cur.port_text) begin
						upd.committed_port = port_res;
						upd.port_committed = 1'b1;
					end
					upd.phase = usp_pkg::PH_PATH;
					section   = usp_pkg::SEC_PATH;
				end else begin
					upd.port_text = 1'b1;
					section       = usp_pkg::SEC_PORT;
					if (cur.port_sub != usp_pkg::PS_DONE) begin
						if (is_digit) begin
							upd.port_acc = (port_mul > {4'd0, usp_pkg::PORT_CAP}) ?
								usp_pkg::PORT_CAP : port_mul[31:0];
							upd.port_sub = usp_pkg::PS_DIGITS;
						end else if (cur.port_sub == usp_pkg::PS_SKIP && is_space) begin
							upd.port_sub = usp_pkg::PS_SKIP;
						end else if (cur.port_sub == usp_pkg::PS_SKIP &&
							(text_byte == usp_pkg::CH_PLUS ||
							text_byte == usp_pkg::CH_MINUS)) begin
							upd.port_neg = text_byte == usp_pkg::CH_MINUS;
							upd.port_sub = usp_pkg::PS_DIGITS;
						end else begin
							upd.port_sub = usp_pkg::PS_DONE;
						end
					end
				end
			end
			usp_pkg::PH_PATH: begin
				section = usp_pkg::SEC_PATH;
			end
			default: begin
				section = usp_pkg::SEC_ERROR;
			end
		endcase
	end

	always_comb begin
		priority case (upd.phase)
			usp_pkg::PH_ERROR:                     status = upd.err;
			usp_pkg::PH_SCHEME:                    status = usp_pkg::ST_NO_COLON;
			usp_pkg::PH_SLASH1, usp_pkg::PH_SLASH2: status = usp_pkg::ST_NO_SLASH;
			usp_pkg::PH_HOST:                      status = usp_pkg::ST_BAD_HOST;
			default:                               status = usp_pkg::ST_OK;
		endcase
	end

	assign report_port = (status == usp_pkg::ST_OK && upd.port_committed) ?
		upd.committed_port : {16'd0, default_port};

	always_comb begin
		res.echo_byte = text_byte;
		res.section   = section;
		res.final_res = last_byte;
		if (last_byte) begin
			res.scheme_code = (status == usp_pkg::ST_OK) ? upd.matched :
				usp_pkg::SCHEME_UNKNOWN;
			res.port_value  = report_port;
			res.status      = status;
			nxt             = usp_pkg::start_state();
		end else begin
			res.scheme_code = usp_pkg::SCHEME_UNKNOWN;
			res.port_value  = '0;
			res.status      = usp_pkg::ST_OK;
			nxt             = upd;
		end
	end

endmodule

`default_nettype wire

/* hdl/url_scheme_host_port_parser_core.sv */
// Top level of the URL scheme/host/port tagger: stream ports, the input and
// result registers, the parse state and the default port register.
// Depends on usp_pkg and usp_step.
`default_nettype none

// Each character of a URL enters as one item and leaves as one result item
// tagged with its section; the result passes through the input register and
// the result register, and waits while the output side stalls. The item marked
// tlast also carries the scheme code, port and status of the whole URL, and the
// parser then starts over for the next URL. One item is taken every clock
// while the output side keeps up: a character is held in the input register,
// and the single parse step that updates the state and forms the result runs
// between that register and the result register. The default port is read
// when a URL is reported and should only be changed between URLs.
module url_scheme_host_port_parser_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // text_byte
	input  wire logic                          s_tlast,  // last_byte
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// echo_byte[7:0], scheme_code[11:8], port_value[43:12], status[46:44], zero
	output logic [usp_pkg::TDATA_W-1:0]        m_tdata,
	output logic [usp_pkg::TUSER_W-1:0]        m_tuser,  // section
	output logic                               m_tlast,  // final_res
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [15:0]                   cfg_data  // default_port
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  valid_s2;
	usp_pkg::result_t      res_s2;
	usp_pkg::parse_state_t state_q;
	usp_pkg::parse_state_t state_nxt;
	usp_pkg::result_t      res_nxt;
	logic [15:0]           default_port_q;
	logic                  advance;

	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	usp_step u_step (
		.cur          (state_q),
		.text_byte    (byte_s1),
		.last_byte    (last_s1),
		.default_port (default_port_q),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_port_q <= 16'd80;
		end else if (cfg_valid && cfg_ready) begin
			default_port_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= usp_pkg::start_state();
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.status, res_s2.port_value, res_s2.scheme_code,
		res_s2.echo_byte};
	assign m_tuser  = res_s2.section;
	assign m_tlast  = res_s2.final_res;

endmodule

`default_nettype wire

/* hdl/usp_checker.sv */
// Port-level checks for the URL tagger and the bind that attaches them.
// Depends on usp_pkg and url_scheme_host_port_parser_core.
`default_nettype none

module usp_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [usp_pkg::TDATA_W-1:0]   m_tdata,
	input wire logic [usp_pkg::TUSER_W-1:0]   m_tuser,
	input wire logic                          m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("Stalled result item changed.");

	a_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[11:8] == usp_pkg::SCHEME_UNKNOWN &&
		m_tdata[43:12] == 32'd0 && m_tdata[46:44] == usp_pkg::ST_OK)
		else $error("Summary fields set on an item that is not final.");

	a_err_scheme: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tdata[46:44] != usp_pkg::ST_OK |->
		m_tdata[11:8] == usp_pkg::SCHEME_UNKNOWN)
		else $error("Failed URL reported with a known scheme.");

	a_err_section: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tuser == usp_pkg::SEC_ERROR |->
		m_tdata[46:44] != usp_pkg::ST_OK)
		else $error("Error section ended with an ok status.");

endmodule

bind url_scheme_host_port_parser_core usp_checker u_usp_checker (.*);

`default_nettype wire
